FILE: rtl/core/madd_pkg.sv
package madd_pkg;

    localparam int LIMB_BITS = 29;

    typedef logic [LIMB_BITS-1:0] limb_t;

    typedef struct packed {
        limb_t a_limb;
        limb_t b_limb;
        limb_t p_limb;
        logic  last_limb;
    } in_item_t;

    typedef struct packed {
        limb_t result_limb;
        logic  result_last;
        logic  was_reduced;
        logic  overflow_flag;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // accept one input item
        logic read;   // fetch next stored limb into the output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_valid;
        logic rd_last;  // next read is the final limb of the run
    } dp_status_t;

endpackage

FILE: rtl/core/madd_ctrl.sv
module madd_ctrl
    import madd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_last,
    output logic       in_ready,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_space;

    assign out_space = !status.out_valid || out_ready;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.read   = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.read = out_space;
                if (out_space && status.rd_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/madd_dp.sv
module madd_dp
    import madd_pkg::*;
#(
    parameter int NUM_LIMBS = 9
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   in_item,
    input  logic       out_ready,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output out_item_t  out_item,
    output logic       out_valid
);

    localparam int CNTW = $clog2(NUM_LIMBS + 1);
    localparam int IDXW = (NUM_LIMBS > 1) ? $clog2(NUM_LIMBS) : 1;
    localparam logic [CNTW-1:0] FULL = CNTW'(NUM_LIMBS);

    limb_t sum_mem  [NUM_LIMBS];
    limb_t diff_mem [NUM_LIMBS];

    logic            carry_reg;
    logic            borrow_reg;
    logic [CNTW-1:0] count_reg;
    logic            ovf_reg;

    logic [CNTW-1:0] run_n_reg;
    logic            run_reduce_reg;
    logic            run_ovf_reg;
    logic [IDXW-1:0] rd_idx_reg;

    limb_t sum_rd_reg;
    limb_t diff_rd_reg;
    logic  out_last_reg;
    logic  out_reduce_reg;
    logic  out_ovf_reg;
    logic  out_valid_reg;

    logic [LIMB_BITS:0] sum_full;
    logic [LIMB_BITS:0] diff_full;
    logic               has_room;
    logic               carry_next;
    logic               borrow_next;
    logic [CNTW-1:0]    count_next;
    logic               ovf_next;
    logic               rd_last;

    assign has_room  = count_reg < FULL;
    assign sum_full  = {1'b0, in_item.a_limb} + {1'b0, in_item.b_limb}
                     + {{LIMB_BITS{1'b0}}, carry_reg};
    assign diff_full = {1'b0, sum_full[LIMB_BITS-1:0]} - {1'b0, in_item.p_limb}
                     - {{LIMB_BITS{1'b0}}, borrow_reg};

    always_comb
    begin
        carry_next  = carry_reg;
        borrow_next = borrow_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        if (has_room)
        begin
            carry_next  = sum_full[LIMB_BITS];
            borrow_next = diff_full[LIMB_BITS];
            count_next  = count_reg + 1'b1;
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    assign rd_last = CNTW'(rd_idx_reg) == (run_n_reg - 1'b1);

    // limb stores: one write port (load), one registered read port (drain)
    always_ff @(posedge clk)
    begin
        if (cmd.load && has_room)
        begin
            sum_mem[count_reg[IDXW-1:0]]  <= sum_full[LIMB_BITS-1:0];
            diff_mem[count_reg[IDXW-1:0]] <= diff_full[LIMB_BITS-1:0];
        end
        if (cmd.read)
        begin
            sum_rd_reg  <= sum_mem[rd_idx_reg];
            diff_rd_reg <= diff_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg      <= 1'b0;
            borrow_reg     <= 1'b0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            run_n_reg      <= '0;
            run_reduce_reg <= 1'b0;
            run_ovf_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            out_last_reg   <= 1'b0;
            out_reduce_reg <= 1'b0;
            out_ovf_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (in_item.last_limb)
                begin
                    // close the run: latch its summary, restart accumulation
                    run_n_reg      <= count_next;
                    run_reduce_reg <= carry_next | ~borrow_next;
                    run_ovf_reg    <= ovf_next;
                    rd_idx_reg     <= '0;
                    carry_reg      <= 1'b0;
                    borrow_reg     <= 1'b0;
                    count_reg      <= '0;
                    ovf_reg        <= 1'b0;
                end
                else
                begin
                    carry_reg  <= carry_next;
                    borrow_reg <= borrow_next;
                    count_reg  <= count_next;
                    ovf_reg    <= ovf_next;
                end
            end
            if (cmd.read)
            begin
                rd_idx_reg     <= rd_idx_reg + 1'b1;
                out_last_reg   <= rd_last;
                out_reduce_reg <= run_reduce_reg;
                out_ovf_reg    <= run_ovf_reg;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_item.result_limb   = out_reduce_reg ? diff_rd_reg : sum_rd_reg;
    assign out_item.result_last   = out_last_reg;
    assign out_item.was_reduced   = out_reduce_reg;
    assign out_item.overflow_flag = out_ovf_reg;
    assign out_valid              = out_valid_reg;

    assign status.out_valid = out_valid_reg;
    assign status.rd_last   = rd_last;

endmodule

FILE: rtl/core/modular_add_limb_serial_top.sv
// Serial (a + b) mod p over 29-bit limbs, least significant limb first. Each
// input item carries one limb of a, b and p; the limb marked last closes the
// run and the block then streams one result item per stored limb, taking the
// difference limbs when the full sum is >= p (was_reduced set) and the sum
// limbs otherwise. Limbs beyond NUM_LIMBS are dropped and overflow_flag is set
// on every result of that run. Timing: a run of N limbs is accepted at one
// limb per cycle, then the N results leave one per cycle while out_ready does
// not stall the output; after the last limb the controller enters its emit
// state and each result is read from the store into the output register, paced
// by the single read port of the limb stores. Input for the next run is taken
// again in the cycle after the final result has been read out of the store.
module modular_add_limb_serial_top
    import madd_pkg::*;
#(
    parameter int NUM_LIMBS = 9
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    dp_cmd_t    cmd;
    dp_status_t status;

    madd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_item.last_limb),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    madd_dp #(
        .NUM_LIMBS (NUM_LIMBS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status),
        .out_item  (out_item),
        .out_valid (out_valid)
    );

endmodule
